// File: rtl/hpte_pkg.sv
// Shared types, constants and a function for the hashed page table entry manager.
package hpte_pkg;

   localparam int TableEntries = 1024;
   localparam int IdxW = $clog2(TableEntries);
   localparam int GroupSlots = 8;
   localparam int SlotW = $clog2(GroupSlots);
   localparam int QueueDepth = 2;

   typedef enum logic [1:0] {
      CMD_ENTER   = 2'd0,
      CMD_REMOVE  = 2'd1,
      CMD_PROTECT = 2'd2,
      CMD_BULK    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_PARM     = 3'd1,
      ST_FULL     = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_END      = 3'd4
   } status_type;

   typedef enum logic [0:0] {
      CSR_INDEX_MASK = 1'd0,
      CSR_RAM_LIMIT  = 1'd1
   } csr_type;

   // Operation the back end carries out on the table.
   typedef enum logic [2:0] {
      OP_DONE    = 3'd0,
      OP_ENTER   = 3'd1,
      OP_REMOVE  = 3'd2,
      OP_PROTECT = 3'd3,
      OP_BULK    = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      BK_IDLE  = 3'd0,
      BK_READ  = 3'd1,
      BK_WAIT  = 3'd2,
      BK_CHECK = 3'd3,
      BK_OUT   = 3'd4
   } bk_state_type;

   // Classified word passed from the front end to the back end.
   typedef struct packed {
      op_type         op;
      status_type     status;
      logic [IdxW-1:0] index;
      logic           exact;
      logic           match_avpn;
      logic           and_cond;
      logic [63:0]    first_word;
      logic [63:0]    second_word;
      logic [63:0]    compare_value;
      logic [13:0]    protect_bits;
      logic [63:0]    bulk_response;
   } job_type;

   // Result word.
   typedef struct packed {
      status_type  status;
      logic [55:0] placed_index;
      logic [63:0] old_first_word;
      logic [63:0] old_second_word;
      logic        invalidate_valid;
      logic [63:0] invalidate_operand;
      logic [63:0] bulk_response;
   } rsp_type;

   // TLB invalidate operand for an entry.
   function automatic logic [63:0] invalidate_word(input logic [63:0] v,
                                                   input logic [IdxW-1:0] ix);
      logic [63:0] rb;
      logic [63:0] lo;
      begin
         rb = {v[63:7], 7'b0} << 16;
         lo = 64'(ix) >> 3;
         if (v[1]) begin
            lo = ~lo;
         end
         if (v[62]) begin
            lo = lo ^ (v >> 24);
         end else begin
            lo = lo ^ (v >> 12);
         end
         lo = lo & 64'h7ff;
         if (v[2]) begin
            rb[0] = 1'b1;
         end else begin
            rb = rb | (lo << 12);
         end
         rb = rb | ((v >> 54) & 64'h300);
         return rb;
      end
   endfunction

endpackage

// File: rtl/hpte_front.sv
// Front end: checks parameters of each command and classifies it for the back end.
module hpte_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [0:0]         csr_index,
   input  logic [61:0]        csr_data,
   input  logic [1:0]         cmd,
   input  logic [55:0]        entry_index,
   input  logic               exact,
   input  logic               match_avpn,
   input  logic               and_cond,
   input  logic [63:0]        entry_first_word,
   input  logic [63:0]        entry_second_word,
   input  logic [63:0]        compare_value,
   input  logic [13:0]        protect_bits,
   input  logic [63:0]        bulk_request,
   output hpte_pkg::job_type  job
);
   import hpte_pkg::*;

   logic [9:0]  index_mask_ff;
   logic [61:0] ram_limit_ff;
   logic        big_page;
   logic [63:0] raddr;
   logic        enter_bad;
   logic [55:0] bulk_ix;
   logic        bulk_ix_bad;
   logic        req_ix_bad;
   logic [63:0] resp;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         index_mask_ff <= 10'h3ff;
         ram_limit_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_type'(csr_index))
            CSR_INDEX_MASK: index_mask_ff <= csr_data[9:0];
            CSR_RAM_LIMIT:  ram_limit_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Index range checks for the plain and the bulk index.
   always_comb begin
      req_ix_bad  = (entry_index[9:0] & ~index_mask_ff) != '0 ||
                    entry_index[55:IdxW] != '0;
      bulk_ix     = bulk_request[55:0];
      bulk_ix_bad = (bulk_ix[9:0] & ~index_mask_ff) != '0 || bulk_ix[55:IdxW] != '0;
   end

   // Page size and storage attribute checks for enter.
   always_comb begin
      big_page = entry_first_word[2];
      raddr = entry_second_word & 64'h3ffffffffffff000;
      if (big_page) begin
         raddr[23:0] = '0;
      end
      enter_bad = 1'b0;
      if (big_page && (entry_second_word[19:12] != '0 || entry_first_word[7])) begin
         enter_bad = 1'b1;
      end else if (raddr < {2'b0, ram_limit_ff}) begin
         enter_bad = entry_second_word[6:3] != 4'b0010;
      end else begin
         enter_bad = entry_second_word[6:4] != 3'b010;
      end
      enter_bad = enter_bad || req_ix_bad;
   end

   // Classification.
   always_comb begin
      resp = {2'b10, 2'b00, bulk_request[59:0]} & 64'h83ffffffffffffff;
      job               = '0;
      job.status        = ST_OK;
      job.index         = entry_index[IdxW-1:0];
      job.exact         = exact;
      job.match_avpn    = match_avpn;
      job.and_cond      = and_cond;
      job.first_word    = entry_first_word & ~64'h60;
      job.second_word   = entry_second_word;
      job.compare_value = compare_value;
      job.protect_bits  = protect_bits;
      unique case (cmd_type'(cmd))
         CMD_ENTER: begin
            job.op     = enter_bad ? OP_DONE : OP_ENTER;
            job.status = enter_bad ? ST_PARM : ST_OK;
         end
         CMD_REMOVE: begin
            job.op     = req_ix_bad ? OP_DONE : OP_REMOVE;
            job.status = req_ix_bad ? ST_PARM : ST_OK;
         end
         CMD_PROTECT: begin
            job.op     = req_ix_bad ? OP_DONE : OP_PROTECT;
            job.status = req_ix_bad ? ST_PARM : ST_OK;
         end
         default: begin
            job.op = OP_DONE;
            if (bulk_request[63:62] == 2'd3) begin
               job.status = ST_END;
            end else if (bulk_request[63:62] != 2'd1) begin
               job.status = ST_PARM;
            end else if (bulk_request[57] && bulk_request[56]) begin
               job.status        = ST_PARM;
               job.bulk_response = resp | 64'h2000000000000000;
            end else if (bulk_ix_bad) begin
               job.status        = ST_PARM;
               job.bulk_response = resp | 64'h2000000000000000;
            end else begin
               job.op            = OP_BULK;
               job.index         = bulk_ix[IdxW-1:0];
               job.match_avpn    = bulk_request[57];
               job.and_cond      = bulk_request[56];
               job.bulk_response = resp;
            end
         end
      endcase
   end

endmodule

// File: rtl/hpte_queue.sv
// Short queue of classified words between the front end and the back end.
module hpte_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  hpte_pkg::job_type  push_job,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output hpte_pkg::job_type  head_job
);
   import hpte_pkg::*;

   localparam int PtrW = $clog2(QueueDepth);

   job_type         slot_ff [QueueDepth];
   logic [PtrW-1:0] rd_ff, rd_in;
   logic [PtrW-1:0] wr_ff, wr_in;
   logic [PtrW:0]   count_ff, count_in;
   logic            do_push, do_pop;

   always_comb begin
      full     = count_ff == (PtrW+1)'(QueueDepth);
      empty    = count_ff == '0;
      do_push  = push && !full;
      do_pop   = pop && !empty;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      count_in = count_ff + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
      head_job = slot_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff    <= '0;
         wr_ff    <= '0;
         count_ff <= '0;
      end else begin
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_job;
      end
   end

   assert property (@(posedge clock) disable iff (reset) full |-> !empty)
      else $error("queue full and empty at once");
   assert property (@(posedge clock) disable iff (reset)
                    count_ff <= (PtrW+1)'(QueueDepth))
      else $error("queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
                    (do_push && !do_pop) |=> !empty)
      else $error("queue lost a word");

endmodule

// File: rtl/hpte_back.sv
// Back end: carries out table reads, writes and group search; holds the result register.
module hpte_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_empty,
   input  hpte_pkg::job_type  job,
   output logic               job_pop,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output hpte_pkg::rsp_type  rsp
);
   import hpte_pkg::*;

   // Table memory: first words carry the valid bit, cleared by a sweep after reset.
   logic [63:0] first_mem [TableEntries];
   logic [63:0] second_mem [TableEntries];

   bk_state_type    state_ff, state_in;
   job_type         job_ff;
   logic [IdxW-1:0] addr_ff, addr_in;
   logic [SlotW:0]  probe_ff, probe_in;
   logic [IdxW:0]   clear_ff;
   logic            clearing;
   logic [63:0]     rd_first_ff, rd_second_ff;
   rsp_type         rsp_ff, rsp_in;
   logic            rsp_valid_ff;
   logic            wr_first, wr_second;
   logic [63:0]     wr_first_data, wr_second_data;
   logic            take_job;
   logic            hit;
   logic [63:0]     new_second;
   logic [63:0]     resp;

   assign clearing = !clear_ff[IdxW];
   assign take_job = state_ff == BK_IDLE && !job_empty && !rsp_valid_ff && !clearing;
   assign job_pop  = take_job;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp = rsp_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:  if (take_job) state_in = (job.op == OP_DONE) ? BK_OUT : BK_READ;
         BK_READ:  state_in = BK_WAIT;
         BK_WAIT:  state_in = BK_CHECK;
         BK_CHECK: begin
            if (job_ff.op == OP_ENTER && !job_ff.exact && rd_first_ff[0] &&
                probe_ff != (SlotW+1)'(GroupSlots - 1)) begin
               state_in = BK_READ;
            end else begin
               state_in = BK_OUT;
            end
         end
         BK_OUT:   state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // Match test and the data written back.
   always_comb begin
      hit = rd_first_ff[0] &&
            !(job_ff.match_avpn && {rd_first_ff[63:7], 7'b0} != job_ff.compare_value) &&
            !(job_ff.and_cond && (rd_first_ff & job_ff.compare_value) != '0 &&
              job_ff.op != OP_PROTECT);
      new_second = rd_second_ff & ~64'hb000000000000e07;
      new_second[63]    = job_ff.protect_bits[8];
      new_second[61:60] = job_ff.protect_bits[13:12];
      new_second[11:9]  = job_ff.protect_bits[11:9];
      new_second[2:0]   = job_ff.protect_bits[2:0];
      resp = job_ff.bulk_response;
   end

   // Outputs of each state: memory writes, address steps and the result.
   always_comb begin
      addr_in        = addr_ff;
      probe_in       = probe_ff;
      wr_first       = 1'b0;
      wr_second      = 1'b0;
      wr_first_data  = '0;
      wr_second_data = '0;
      rsp_in         = rsp_ff;
      if (clearing) begin
         wr_first  = 1'b1;
         wr_second = 1'b1;
      end
      unique case (state_ff)
         BK_IDLE: begin
            probe_in = '0;
            if (job.op == OP_ENTER && !job.exact) begin
               addr_in = {job.index[IdxW-1:SlotW], SlotW'(0)};
            end else begin
               addr_in = job.index;
            end
            // In idle, the result register changes only when a new word is taken.
            if (take_job) begin
               rsp_in        = '0;
               rsp_in.status = job.status;
               rsp_in.bulk_response = job.bulk_response;
            end
         end
         BK_CHECK: begin
            unique case (job_ff.op)
               OP_ENTER: begin
                  if (rd_first_ff[0]) begin
                     if (job_ff.exact || probe_ff == (SlotW+1)'(GroupSlots - 1)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        probe_in = probe_ff + 1'b1;
                        addr_in  = addr_ff + 1'b1;
                     end
                  end else begin
                     wr_first       = 1'b1;
                     wr_second      = 1'b1;
                     wr_first_data  = job_ff.first_word;
                     wr_second_data = job_ff.second_word;
                     rsp_in.status  = ST_OK;
                     rsp_in.placed_index = 56'(addr_ff);
                  end
               end
               OP_REMOVE, OP_BULK, OP_PROTECT: begin
                  if (hit) begin
                     rsp_in.status             = ST_OK;
                     rsp_in.old_first_word     = rd_first_ff;
                     rsp_in.old_second_word    = rd_second_ff;
                     rsp_in.invalidate_valid   = 1'b1;
                     rsp_in.invalidate_operand = invalidate_word(rd_first_ff, addr_ff);
                     if (job_ff.op == OP_PROTECT) begin
                        wr_second      = 1'b1;
                        wr_second_data = new_second;
                     end else begin
                        wr_first = 1'b1;
                     end
                     if (job_ff.op == OP_BULK) begin
                        rsp_in.bulk_response = resp | ((rd_second_ff & 64'h180) << 43);
                     end
                  end else begin
                     rsp_in.status = (job_ff.op == OP_BULK) ? ST_OK : ST_NOTFOUND;
                     if (job_ff.op == OP_BULK) begin
                        rsp_in.bulk_response = resp | 64'h1000000000000000;
                     end
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         clear_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clearing) begin
            clear_ff <= clear_ff + 1'b1;
         end
         if (state_ff == BK_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (take_job) begin
         job_ff <= job;
      end
      addr_ff  <= addr_in;
      probe_ff <= probe_in;
      rsp_ff   <= rsp_in;
   end

   // Table memory, one port each.
   always_ff @(posedge clock) begin
      if (wr_first) begin
         first_mem[clearing ? clear_ff[IdxW-1:0] : addr_ff] <= wr_first_data;
      end
      if (wr_second) begin
         second_mem[clearing ? clear_ff[IdxW-1:0] : addr_ff] <= wr_second_data;
      end
      if (state_ff == BK_READ) begin
         rd_first_ff  <= first_mem[addr_ff];
         rd_second_ff <= second_mem[addr_ff];
      end
   end

   assert property (@(posedge clock) disable iff (reset) clearing |-> state_ff == BK_IDLE)
      else $error("job started during table clear");
   assert property (@(posedge clock) disable iff (reset) take_job |-> !rsp_valid_ff)
      else $error("job taken while result pending");
   assert property (@(posedge clock) disable iff (reset)
                    state_ff == BK_OUT |=> rsp_valid_ff)
      else $error("result not presented");

endmodule

// File: rtl/hashed_page_table_entry_manager.sv
// Top level of the hashed page table entry manager.
// After reset the block clears its 1024-entry table, then takes commands:
// a word is classified on push, waits in a two-deep queue, and the back end runs it
// against the single table memory port through the read, wait, check and output states,
// or straight to output for a word that needs no table access; a non-exact enter probes
// its group one slot at a time. One result is held until popped.
module hashed_page_table_entry_manager (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   output logic         empty,
   input  logic         pop,
   input  logic         csr_write,
   input  logic [0:0]   csr_index,
   input  logic [61:0]  csr_data,
   input  logic [1:0]   req_cmd,
   input  logic [55:0]  req_entry_index,
   input  logic         req_exact,
   input  logic         req_match_avpn,
   input  logic         req_and_cond,
   input  logic [63:0]  req_entry_first_word,
   input  logic [63:0]  req_entry_second_word,
   input  logic [63:0]  req_compare_value,
   input  logic [13:0]  req_protect_bits,
   input  logic [63:0]  req_bulk_request,
   output logic [2:0]   rsp_status,
   output logic [55:0]  rsp_placed_index,
   output logic [63:0]  rsp_old_first_word,
   output logic [63:0]  rsp_old_second_word,
   output logic         rsp_invalidate_valid,
   output logic [63:0]  rsp_invalidate_operand,
   output logic [63:0]  rsp_bulk_response
);
   import hpte_pkg::*;

   job_type front_job;
   job_type head_job;
   logic    q_empty;
   logic    q_pop;
   rsp_type rsp;

   hpte_front u_front (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .cmd(req_cmd), .entry_index(req_entry_index), .exact(req_exact),
      .match_avpn(req_match_avpn), .and_cond(req_and_cond),
      .entry_first_word(req_entry_first_word), .entry_second_word(req_entry_second_word),
      .compare_value(req_compare_value), .protect_bits(req_protect_bits),
      .bulk_request(req_bulk_request), .job(front_job)
   );

   hpte_queue u_queue (
      .clock, .reset, .push, .push_job(front_job), .full,
      .pop(q_pop), .empty(q_empty), .head_job
   );

   hpte_back u_back (
      .clock, .reset, .job_empty(q_empty), .job(head_job), .job_pop(q_pop),
      .rsp_empty(empty), .rsp_pop(pop), .rsp
   );

   assign rsp_status             = rsp.status;
   assign rsp_placed_index       = rsp.placed_index;
   assign rsp_old_first_word     = rsp.old_first_word;
   assign rsp_old_second_word    = rsp.old_second_word;
   assign rsp_invalidate_valid   = rsp.invalidate_valid;
   assign rsp_invalidate_operand = rsp.invalidate_operand;
   assign rsp_bulk_response      = rsp.bulk_response;

endmodule

// File: tb/tb_hashed_page_table_entry_manager.sv
// Testbench for the hashed page table entry manager: directed and random commands checked against a local table model.
`timescale 1ns / 1ps
module tb_hashed_page_table_entry_manager;
   import hpte_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full, empty;
   logic csr_write = 1'b0;
   logic [0:0] csr_index = '0;
   logic [61:0] csr_data = '0;
   logic [1:0] req_cmd = '0;
   logic [55:0] req_entry_index = '0;
   logic req_exact = 1'b0, req_match_avpn = 1'b0, req_and_cond = 1'b0;
   logic [63:0] req_entry_first_word = '0, req_entry_second_word = '0;
   logic [63:0] req_compare_value = '0, req_bulk_request = '0;
   logic [13:0] req_protect_bits = '0;
   logic [2:0] rsp_status;
   logic [55:0] rsp_placed_index;
   logic [63:0] rsp_old_first_word, rsp_old_second_word;
   logic rsp_invalidate_valid;
   logic [63:0] rsp_invalidate_operand, rsp_bulk_response;

   hashed_page_table_entry_manager u_top (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // Local copy of the table and registers.
   logic [63:0] table_hi [TableEntries];
   logic [63:0] table_lo [TableEntries];
   logic [9:0] mask_q = 10'h3ff;
   logic [61:0] limit_q = '0;
   rsp_type outcome_q [$];
   int errors = 0;
   int send_idle = 0;
   int recv_idle = 0;

   // Fields of one command word.
   typedef struct {
      logic [1:0] cmd;
      logic [55:0] ix;
      logic ex, av, ac;
      logic [63:0] w1, w2, cv, bulk;
      logic [13:0] pb;
   } cmd_word;

   function automatic bit ix_bad(logic [55:0] ix);
      return ((ix & ~56'(mask_q)) != 0) || (ix >= TableEntries);
   endfunction

   function automatic logic [63:0] tlbie_operand(logic [63:0] v, logic [55:0] ix);
      logic [63:0] rb, lo;
      rb = (v & ~64'h7f) << 16;
      lo = 64'(ix) >> 3;
      if (v[1]) lo = ~lo;
      lo = v[62] ? lo ^ (v >> 24) : lo ^ (v >> 12);
      lo &= 64'h7ff;
      if (v[2]) rb |= 64'h1;
      else rb |= lo << 12;
      rb |= (v >> 54) & 64'h300;
      return rb;
   endfunction

   // Returns 0 removed, 1 not found, 2 bad index.
   function automatic int remove_entry(logic [55:0] ix, logic [63:0] cv, bit av, bit ac,
                                       ref rsp_type r);
      logic [63:0] v;
      if (ix_bad(ix)) return 2;
      v = table_hi[ix[9:0]];
      if (!v[0] || (av && ((v & ~64'h7f) != cv)) || (ac && ((v & cv) != 0))) return 1;
      r.old_first_word = v;
      r.old_second_word = table_lo[ix[9:0]];
      r.invalidate_valid = 1'b1;
      r.invalidate_operand = tlbie_operand(v, ix);
      table_hi[ix[9:0]] = '0;
      return 0;
   endfunction

   function automatic rsp_type predict_outcome(cmd_word c);
      rsp_type r;
      int rc, sh, i;
      logic [63:0] h, l, ra, resp;
      logic [55:0] slot;
      r = '0;
      case (c.cmd)
         CMD_ENTER: begin
            h = c.w1;
            l = c.w2;
            sh = 12;
            r.status = ST_OK;
            if (h[2]) begin
               if ((l & 64'hff000) != 0 || h[7]) r.status = ST_PARM;
               sh = 24;
            end
            ra = l & 64'h3ffffffffffff000 & ~((64'h1 << sh) - 1);
            if (r.status == ST_OK) begin
               if (ra < 64'(limit_q)) begin
                  if ((l & 64'h78) != 64'h10) r.status = ST_PARM;
               end else if ((l & 64'h70) != 64'h20) r.status = ST_PARM;
            end
            h &= ~64'h60;
            if (r.status == ST_OK && ix_bad(c.ix)) r.status = ST_PARM;
            if (r.status == ST_OK) begin
               if (c.ex) begin
                  slot = c.ix;
                  if (table_hi[slot[9:0]][0]) r.status = ST_FULL;
               end else begin
                  for (i = 0; i < GroupSlots; i++) begin
                     slot = (c.ix & ~56'h7) + 56'(i);
                     if (slot < TableEntries && !table_hi[slot[9:0]][0]) break;
                  end
                  if (i == GroupSlots) r.status = ST_FULL;
               end
            end
            if (r.status == ST_OK) begin
               table_lo[slot[9:0]] = l;
               table_hi[slot[9:0]] = h;
               r.placed_index = slot;
            end
         end
         CMD_REMOVE: begin
            rc = remove_entry(c.ix, c.cv, c.av, c.ac, r);
            r.status = rc == 0 ? ST_OK : rc == 1 ? ST_NOTFOUND : ST_PARM;
         end
         CMD_PROTECT: begin
            if (ix_bad(c.ix)) r.status = ST_PARM;
            else begin
               h = table_hi[c.ix[9:0]];
               l = table_lo[c.ix[9:0]];
               if (!h[0] || (c.av && ((h & ~64'h7f) != c.cv))) r.status = ST_NOTFOUND;
               else begin
                  r.old_first_word = h;
                  r.old_second_word = l;
                  l &= ~64'hb000000000000e07;
                  l |= (64'(c.pb) << 55) & 64'h8000000000000000;
                  l |= (64'(c.pb) << 48) & 64'h3000000000000000;
                  l |= 64'(c.pb) & 64'he07;
                  table_lo[c.ix[9:0]] = l;
                  r.status = ST_OK;
                  r.invalidate_valid = 1'b1;
                  r.invalidate_operand = tlbie_operand(h, c.ix);
               end
            end
         end
         default: begin
            if (c.bulk[63:62] == 2'd3) r.status = ST_END;
            else if (c.bulk[63:62] != 2'd1) r.status = ST_PARM;
            else begin
               resp = (c.bulk & 64'h03ffffffffffffff) | 64'h8000000000000000;
               if (resp[56] && resp[57]) begin
                  r.status = ST_PARM;
                  r.bulk_response = resp | 64'h2000000000000000;
               end else begin
                  rc = remove_entry(c.bulk[55:0], c.cv, c.bulk[57], c.bulk[56], r);
                  resp |= 64'(rc) << 60;
                  if (rc == 0) resp |= (r.old_second_word & 64'h180) << 43;
                  r.status = rc == 2 ? ST_PARM : ST_OK;
                  r.bulk_response = resp;
               end
            end
         end
      endcase
      return r;
   endfunction

   // Sends one word and records its expected outcome once accepted.
   task automatic send_cmd(cmd_word c);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_cmd <= c.cmd;
      req_entry_index <= c.ix;
      req_exact <= c.ex;
      req_match_avpn <= c.av;
      req_and_cond <= c.ac;
      req_entry_first_word <= c.w1;
      req_entry_second_word <= c.w2;
      req_compare_value <= c.cv;
      req_protect_bits <= c.pb;
      req_bulk_request <= c.bulk;
      do @(posedge clock); while (full);
      outcome_q.push_back(predict_outcome(c));
   endtask

   // Pops results with random stalls and compares each field.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && pop && !empty) begin
         if (outcome_q.size() == 0) begin
            $error("unexpected word, status %0d", rsp_status);
            errors++;
         end else begin
            e = outcome_q.pop_front();
            if (rsp_status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status); errors++;
            end
            if (rsp_placed_index !== e.placed_index) begin
               $error("placed_index exp %h got %h", e.placed_index, rsp_placed_index);
               errors++;
            end
            if (rsp_old_first_word !== e.old_first_word) begin
               $error("old_first_word exp %h got %h", e.old_first_word, rsp_old_first_word);
               errors++;
            end
            if (rsp_old_second_word !== e.old_second_word) begin
               $error("old_second_word exp %h got %h", e.old_second_word,
                      rsp_old_second_word);
               errors++;
            end
            if (rsp_invalidate_valid !== e.invalidate_valid) begin
               $error("invalidate_valid exp %0d got %0d", e.invalidate_valid,
                      rsp_invalidate_valid);
               errors++;
            end
            if (rsp_invalidate_operand !== e.invalidate_operand) begin
               $error("invalidate_operand exp %h got %h", e.invalidate_operand,
                      rsp_invalidate_operand);
               errors++;
            end
            if (rsp_bulk_response !== e.bulk_response) begin
               $error("bulk_response exp %h got %h", e.bulk_response, rsp_bulk_response);
               errors++;
            end
         end
      end
      pop <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
   end

   task automatic drain_queue();
      push <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(csr_type idx, logic [61:0] val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_INDEX_MASK) mask_q = val[9:0];
      else limit_q = val;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Well-formed entry words: valid, mostly with WIMG bits that suit RAM or non-RAM.
   function automatic cmd_word make_enter(logic [55:0] ix, bit ex);
      cmd_word c;
      c = '{default: '0};
      c.cmd = CMD_ENTER;
      c.ix = ix;
      c.ex = ex;
      c.w1 = rand64() | 64'h1;
      if ($urandom_range(3) != 0) c.w1[7] = 1'b0;
      c.w2 = rand64();
      if ($urandom_range(3) != 0) c.w2[19:12] = '0;
      if ($urandom_range(1)) c.w2[6:3] = 4'b0010;
      else c.w2[6:3] = {1'b0, 3'b100};
      if ($urandom_range(4) == 0) c.w2[6:3] = 4'($urandom);
      c.cv = rand64();
      c.bulk = rand64();
      c.pb = 14'($urandom);
      return c;
   endfunction

   function automatic cmd_word random_cmd();
      cmd_word c;
      logic [55:0] ix;
      int k;
      ix = ($urandom_range(9) == 0) ? 56'(rand64()) : 56'($urandom_range(63));
      k = $urandom_range(9);
      c = make_enter(ix, $urandom_range(3) == 0);
      if (k < 4) return c;
      c.cmd = (k < 6) ? CMD_REMOVE : (k < 8) ? CMD_PROTECT : CMD_BULK;
      c.av = $urandom_range(3) == 0;
      c.ac = $urandom_range(3) == 0;
      if (c.av && ix < TableEntries) c.cv = table_hi[ix[9:0]] & ~64'h7f;
      if (c.ac && $urandom_range(1)) c.cv = '0;
      c.bulk[63:62] = ($urandom_range(7) == 0) ? 2'($urandom) : 2'd1;
      c.bulk[55:0] = ix;
      if ($urandom_range(5) != 0) c.bulk[61:58] = '0;
      if ($urandom_range(3) != 0) c.bulk[57:56] = 2'($urandom);
      return c;
   endfunction

   // Extremes, every command and the named corner cases.
   task automatic test_directed();
      cmd_word c;
      c = make_enter(56'd0, 1'b0); c.w1 = '1; c.w2 = 64'h0000000000000020; c.w1[7] = 1'b0;
      send_cmd(c);
      c = make_enter(56'd0, 1'b1); c.w2[6:3] = 4'b0010; send_cmd(c);
      c = make_enter(56'd1023, 1'b0); c.w1 = 64'h1; c.w2 = 64'h20; send_cmd(c);
      c = make_enter(56'hffffffffffffff, 1'b0); send_cmd(c);
      c = make_enter(56'd1024, 1'b1); send_cmd(c);
      repeat (9) begin
         c = make_enter(56'd16, 1'b0); c.w1[2] = 1'b0; c.w2[6:3] = 4'b0100; send_cmd(c);
      end
      c = make_enter(56'd16, 1'b1); c.w1[2] = 1'b1; c.w1[7] = 1'b1; send_cmd(c);
      c = random_cmd(); c.cmd = CMD_REMOVE; c.ix = 56'd16; c.av = 1'b0; c.ac = 1'b0;
      send_cmd(c);
      c.ix = 56'd17; c.av = 1'b1; c.cv = table_hi[17] & ~64'h7f; send_cmd(c);
      c.cmd = CMD_PROTECT; c.ix = 56'd18; c.av = 1'b0; c.pb = '1; send_cmd(c);
      c.pb = '0; send_cmd(c);
      c.cmd = CMD_REMOVE; c.ix = 56'd19; c.ac = 1'b1; c.cv = '1; send_cmd(c);
      c.cmd = CMD_BULK; c.bulk = 64'hc000000000000000; send_cmd(c);
      c.bulk = 64'h0000000000000013; send_cmd(c);
      c.bulk = 64'h4300000000000013; send_cmd(c);
      c.bulk = 64'h4000000000000013; send_cmd(c);
      c.bulk = 64'h4000000000000013; send_cmd(c);
      c.bulk = 64'h7fffffffffffffff; send_cmd(c);
      drain_queue();
   endtask

   task automatic test_random(int n, int si, int ri);
      send_idle = si;
      recv_idle = ri;
      repeat (n) send_cmd(random_cmd());
      drain_queue();
      send_idle = 0;
      recv_idle = 0;
   endtask

   initial begin
      foreach (table_hi[i]) begin
         table_hi[i] = '0;
         table_lo[i] = '0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (full) @(posedge clock);
      test_directed();
      test_random(140, 0, 0);
      write_csr(CSR_RAM_LIMIT, 62'h3fffffffffffffff);
      test_random(140, 59, 0);
      write_csr(CSR_INDEX_MASK, 62'h03f);
      write_csr(CSR_RAM_LIMIT, 62'h0000000001000000);
      test_random(140, 0, 59);
      write_csr(CSR_INDEX_MASK, 62'h0);
      write_csr(CSR_RAM_LIMIT, 62'h0);
      test_random(30, 28, 28);
      write_csr(CSR_INDEX_MASK, 62'h3ff);
      write_csr(CSR_RAM_LIMIT, 62'(rand64()));
      test_random(110, 28, 28);
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end
endmodule
